// ===== src/stack_boundary_tag_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Stack boundary-tag allocator assertion macros
// Clocked, reset-gated property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef STACK_BOUNDARY_TAG_ALLOCATOR_ASSERT_SVH
`define STACK_BOUNDARY_TAG_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define SBTA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sbta assertion failed");

// next-cycle implication
`define SBTA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sbta assertion failed");

`endif

// ===== src/sbta_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack boundary-tag allocator package
// Tag constants, micro-operation codes and controller status type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbta_pkg;

    localparam logic [31:0] TAG_FREE     = 32'h8000_0000;
    localparam logic [31:0] TAG_PREVFREE = 32'h2000_0000;
    localparam logic [31:0] TAG_SIZE     = 32'h0FFF_FFFF;
    localparam logic [10:0] RESERVE_RST  = 11'd64;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_EVAL,
        CMD_A_RD,
        CMD_A_CLR,
        CMD_A_PUSH,
        CMD_P_RD,
        CMD_P_ADD,
        CMD_P_NX,
        CMD_R_RD,
        CMD_R_CUR,
        CMD_R_FOOT,
        CMD_R_LO,
        CMD_R_NXRD,
        CMD_R_NX,
        CMD_R_FOOTW,
        CMD_R_PF,
        CMD_R_FR,
        CMD_OUT
    } cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic alloc_fail;
        logic rel_skip;
        logic rel_bottom;
        logic top_full;
        logic cur_prevfree;
        logic lo_ok;
        logic nx_free;
    } stat_t;

endpackage

// ===== src/sbta_ctrl.sv =====
// ----------------------------------------------------------------------------
// Stack boundary-tag allocator controller
// Sequences the tag reads and writes of one request and the output transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbta_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  sbta_pkg::stat_t stat,
    output sbta_pkg::cmd_t  cmd
);

    typedef enum logic [17:0] {
        ST_IDLE    = 18'h00001,
        ST_EVAL    = 18'h00002,
        ST_A_RD    = 18'h00004,
        ST_A_CLR   = 18'h00008,
        ST_A_PUSH  = 18'h00010,
        ST_P_RD    = 18'h00020,
        ST_P_ADD   = 18'h00040,
        ST_P_NX    = 18'h00080,
        ST_R_RD    = 18'h00100,
        ST_R_CUR   = 18'h00200,
        ST_R_FOOT  = 18'h00400,
        ST_R_LO    = 18'h00800,
        ST_R_NXRD  = 18'h01000,
        ST_R_NX    = 18'h02000,
        ST_R_FOOTW = 18'h04000,
        ST_R_PF    = 18'h08000,
        ST_R_FR    = 18'h10000,
        ST_DONE    = 18'h20000
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd         = sbta_pkg::CMD_NONE;
        mvalid_next = mvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd        = sbta_pkg::CMD_LOAD;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd = sbta_pkg::CMD_EVAL;
                priority if (stat.is_alloc) begin
                    state_next = stat.alloc_fail ? ST_DONE : ST_A_RD;
                end else if (stat.rel_skip) begin
                    state_next = ST_DONE;
                end else if (stat.rel_bottom) begin
                    state_next = ST_P_RD;
                end else begin
                    state_next = ST_R_RD;
                end
            end
            ST_A_RD: begin
                cmd        = sbta_pkg::CMD_A_RD;
                state_next = ST_A_CLR;
            end
            ST_A_CLR: begin
                cmd        = sbta_pkg::CMD_A_CLR;
                state_next = ST_A_PUSH;
            end
            ST_A_PUSH: begin
                cmd        = sbta_pkg::CMD_A_PUSH;
                state_next = ST_DONE;
            end
            ST_P_RD: begin
                cmd        = sbta_pkg::CMD_P_RD;
                state_next = ST_P_ADD;
            end
            ST_P_ADD: begin
                cmd        = sbta_pkg::CMD_P_ADD;
                state_next = stat.top_full ? ST_DONE : ST_P_NX;
            end
            ST_P_NX: begin
                cmd        = sbta_pkg::CMD_P_NX;
                state_next = ST_DONE;
            end
            ST_R_RD: begin
                cmd        = sbta_pkg::CMD_R_RD;
                state_next = ST_R_CUR;
            end
            ST_R_CUR: begin
                cmd        = sbta_pkg::CMD_R_CUR;
                state_next = stat.cur_prevfree ? ST_R_FOOT : ST_R_NXRD;
            end
            ST_R_FOOT: begin
                cmd        = sbta_pkg::CMD_R_FOOT;
                state_next = stat.lo_ok ? ST_R_LO : ST_R_NXRD;
            end
            ST_R_LO: begin
                cmd        = sbta_pkg::CMD_R_LO;
                state_next = ST_R_NXRD;
            end
            ST_R_NXRD: begin
                cmd        = sbta_pkg::CMD_R_NXRD;
                state_next = ST_R_NX;
            end
            ST_R_NX: begin
                cmd        = sbta_pkg::CMD_R_NX;
                state_next = ST_R_FOOTW;
            end
            ST_R_FOOTW: begin
                cmd        = sbta_pkg::CMD_R_FOOTW;
                state_next = stat.nx_free ? ST_DONE : ST_R_PF;
            end
            ST_R_PF: begin
                cmd        = sbta_pkg::CMD_R_PF;
                state_next = ST_R_FR;
            end
            ST_R_FR: begin
                cmd        = sbta_pkg::CMD_R_FR;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!mvalid_reg || m_tready) begin
                    cmd         = sbta_pkg::CMD_OUT;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = mvalid_reg;

endmodule

// ===== src/sbta_dp.sv =====
// ----------------------------------------------------------------------------
// Stack boundary-tag allocator datapath
// Tag memory, stack top, reserve register and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbta_dp #(
    parameter int BUF_BYTES = 16384
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  sbta_pkg::cmd_t  cmd,
    output sbta_pkg::stat_t stat,
    input  logic            req_type,
    input  logic [14:0]     req_size,
    input  logic [14:0]     block_offset,
    input  logic            cfg_we,
    input  logic [10:0]     cfg_wdata,
    output logic [14:0]     result_offset,
    output logic            status,
    output logic [14:0]     top_now
);

    localparam int WORDS = BUF_BYTES / 4 + 1;
    localparam int LAST  = BUF_BYTES / 4;
    localparam int AW    = $clog2(WORDS);
    localparam int TW    = $clog2(BUF_BYTES + 1);
    localparam int CW    = ((TW > 16) ? TW : 16) + 2;
    localparam int SW    = 31;
    localparam int IW    = 35;

    logic [31:0]          mem [WORDS];
    logic [31:0]          rdata_raw_reg;
    logic                 rzero_reg;
    logic                 lastw_reg;
    logic                 type_reg;
    logic [14:0]          size_reg;
    logic [14:0]          off_reg;
    logic [TW-1:0]        top_reg;
    logic [10:0]          rsv_reg;
    logic [AW-1:0]        idx_reg;
    logic [AW-1:0]        lo_reg;
    logic [31:0]          cur_reg;
    logic [31:0]          nx_reg;
    logic [14:0]          res_reg;
    logic                 stf_reg;
    logic [14:0]          out_res_reg;
    logic                 out_stat_reg;
    logic [14:0]          out_top_reg;

    logic [31:0]          rdata;
    logic [13:0]          words;
    logic [15:0]          words_b;
    logic                 alloc_fail;
    logic [TW-1:0]        new_top;
    logic [12:0]          hdr;
    logic [SW-1:0]        pop_sum;
    logic [TW-1:0]        top_sat;
    logic signed [IW-1:0] i_s;
    logic signed [IW-1:0] sz_s;
    logic signed [IW-1:0] lo_s;
    logic signed [IW-1:0] nxt_s;
    logic signed [IW-1:0] foot_s;
    logic [31:0]          merged_lo;
    logic [31:0]          merged_nx;
    logic [31:0]          tag_i;
    logic                 rd_en;
    logic signed [IW-1:0] rd_s;
    logic                 wr_req;
    logic signed [IW-1:0] wr_s;
    logic [31:0]          wr_data;
    logic                 wr_go;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;

    function automatic logic in_rng(input logic signed [IW-1:0] x);
        in_rng = !x[IW-1] && (x < signed'(IW'(WORDS)));
    endfunction

    assign rdata     = rzero_reg ? 32'd0 : rdata_raw_reg;
    assign words     = (size_reg == 15'd0) ? 14'd1 : 14'((size_reg - 15'd1) >> 2) + 14'd2;
    assign words_b   = {words, 2'b00};
    assign alloc_fail = CW'(top_reg) < (CW'(words_b) + CW'(rsv_reg));
    assign new_top   = top_reg - TW'(words_b);
    assign hdr       = 13'((off_reg - 15'd4) >> 2);
    assign pop_sum   = SW'(top_reg) + SW'({rdata[27:0], 2'b00});
    assign top_sat   = (pop_sum > SW'(BUF_BYTES)) ? TW'(BUF_BYTES) : TW'(pop_sum);
    assign i_s       = signed'(IW'(idx_reg));
    assign sz_s      = signed'(IW'(cur_reg[27:0]));
    assign lo_s      = i_s - signed'(IW'(rdata)) - signed'(IW'(1));
    assign nxt_s     = i_s + sz_s;
    assign foot_s    = nxt_s - signed'(IW'(1));
    assign merged_lo = ((rdata + cur_reg) & sbta_pkg::TAG_SIZE) | sbta_pkg::TAG_FREE;
    assign merged_nx = merged_lo;

    always_comb begin
        priority if (cur_reg[27:0] == 28'd1) begin
            tag_i = 32'd0;
        end else if (cur_reg[27:0] == 28'd0) begin
            tag_i = nx_reg | sbta_pkg::TAG_PREVFREE;
        end else begin
            tag_i = cur_reg;
        end
    end

    always_comb begin
        stat.is_alloc     = !type_reg;
        stat.alloc_fail   = alloc_fail;
        stat.rel_skip     = (off_reg < 15'd4)
                            || (32'(hdr) < (32'(top_reg) >> 2))
                            || (32'(hdr) >= 32'(LAST));
        stat.rel_bottom   = 32'(hdr) == (32'(top_reg) >> 2);
        stat.top_full     = top_sat == TW'(BUF_BYTES);
        stat.cur_prevfree = rdata[29];
        stat.lo_ok        = in_rng(lo_s);
        stat.nx_free      = nx_reg[31];
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_s    = '0;
        wr_req  = 1'b0;
        wr_s    = '0;
        wr_data = '0;
        unique case (cmd)
            sbta_pkg::CMD_A_RD: begin
                rd_en = 1'b1;
                rd_s  = signed'(IW'(top_reg >> 2));
            end
            sbta_pkg::CMD_A_CLR: begin
                wr_req  = 1'b1;
                wr_s    = signed'(IW'(top_reg >> 2));
                wr_data = rdata & sbta_pkg::TAG_SIZE;
            end
            sbta_pkg::CMD_A_PUSH: begin
                wr_req  = 1'b1;
                wr_s    = signed'(IW'(new_top >> 2));
                wr_data = 32'(words);
            end
            sbta_pkg::CMD_P_RD, sbta_pkg::CMD_R_RD: begin
                rd_en = 1'b1;
                rd_s  = signed'(IW'(hdr));
            end
            sbta_pkg::CMD_P_ADD: begin
                rd_en = 1'b1;
                rd_s  = signed'(IW'(top_sat >> 2));
            end
            sbta_pkg::CMD_R_CUR: begin
                rd_en = 1'b1;
                rd_s  = i_s - signed'(IW'(1));
            end
            sbta_pkg::CMD_R_FOOT: begin
                rd_en = 1'b1;
                rd_s  = lo_s;
            end
            sbta_pkg::CMD_R_LO: begin
                wr_req  = 1'b1;
                wr_s    = signed'(IW'(lo_reg));
                wr_data = merged_lo;
            end
            sbta_pkg::CMD_R_NXRD: begin
                rd_en = 1'b1;
                rd_s  = nxt_s;
            end
            sbta_pkg::CMD_R_NX: begin
                wr_req  = rdata[31];
                wr_s    = i_s;
                wr_data = merged_nx;
            end
            sbta_pkg::CMD_R_FOOTW: begin
                wr_req  = 1'b1;
                wr_s    = foot_s;
                wr_data = {4'd0, cur_reg[27:0]} - 32'd1;
            end
            sbta_pkg::CMD_R_PF: begin
                wr_req  = 1'b1;
                wr_s    = nxt_s;
                wr_data = nx_reg | sbta_pkg::TAG_PREVFREE;
            end
            sbta_pkg::CMD_R_FR: begin
                wr_req  = 1'b1;
                wr_s    = i_s;
                wr_data = tag_i | sbta_pkg::TAG_FREE;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign wr_go   = wr_req && in_rng(wr_s);
    assign wr_addr = wr_s[AW-1:0];
    assign rd_addr = rd_s[AW-1:0];

    always_ff @(posedge aclk) begin
        if (wr_go) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg   <= TW'(BUF_BYTES);
            rsv_reg   <= sbta_pkg::RESERVE_RST;
            lastw_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                rsv_reg <= cfg_wdata;
            end
            if (wr_go && (wr_addr == AW'(LAST))) begin
                lastw_reg <= 1'b1;
            end
            unique case (cmd)
                sbta_pkg::CMD_A_PUSH: top_reg <= new_top;
                sbta_pkg::CMD_P_ADD:  top_reg <= top_sat;
                sbta_pkg::CMD_P_NX: begin
                    if (rdata[31]) begin
                        top_reg <= top_sat;
                    end
                end
                default: top_reg <= top_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rzero_reg <= !in_rng(rd_s) || ((rd_addr == AW'(LAST)) && !lastw_reg);
        end
        unique case (cmd)
            sbta_pkg::CMD_LOAD: begin
                type_reg <= req_type;
                size_reg <= req_size;
                off_reg  <= block_offset;
            end
            sbta_pkg::CMD_EVAL: begin
                res_reg <= 15'd0;
                stf_reg <= !type_reg && alloc_fail;
            end
            sbta_pkg::CMD_A_PUSH: begin
                res_reg <= 15'(32'(new_top) + 32'd4);
            end
            sbta_pkg::CMD_R_RD: begin
                idx_reg <= AW'(hdr);
            end
            sbta_pkg::CMD_R_CUR: begin
                cur_reg <= rdata;
            end
            sbta_pkg::CMD_R_FOOT: begin
                lo_reg <= lo_s[AW-1:0];
            end
            sbta_pkg::CMD_R_LO: begin
                cur_reg <= merged_lo;
                idx_reg <= lo_reg;
            end
            sbta_pkg::CMD_R_NX: begin
                nx_reg <= rdata;
                if (rdata[31]) begin
                    cur_reg <= merged_nx;
                end
            end
            sbta_pkg::CMD_OUT: begin
                out_res_reg  <= res_reg;
                out_stat_reg <= stf_reg;
                out_top_reg  <= 15'(32'(top_reg));
            end
            default: begin
                out_res_reg <= out_res_reg;
            end
        endcase
    end

    assign result_offset = out_res_reg;
    assign status        = out_stat_reg;
    assign top_now       = out_top_reg;

endmodule

// ===== src/stack_boundary_tag_allocator.sv =====
// ----------------------------------------------------------------------------
// Stack boundary-tag allocator
// Carves blocks downward from the buffer top and releases them with
// boundary-tag merging of free neighbours.
//
//   channel   direction  payload
//   s_        in         tuser: req_type; tdata: req_size, block_offset
//   m_        out        tuser: status;   tdata: result_offset, top_now
//   cfg_      in         reserve_bytes
//
// Each request runs as a chain of dependent tag accesses, one step each on the
// single tag memory port: a successful allocate reads, clears and pushes tags,
// a refused allocate or an ignored release goes straight to the result, and
// any other release reads neighbour tags and merges free neighbours.
// Reset sets the stack top to the buffer size and the reserve to 64 bytes.
// A new request is taken while the previous result waits in the output
// register; the final step holds while that register is still full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_boundary_tag_allocator #(
    parameter int BUF_BYTES = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // req_size, block_offset
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // result_offset, top_now
    output logic        m_tuser,   // status
    input  logic        cfg_we,
    input  logic [10:0] cfg_wdata
);

    sbta_pkg::cmd_t  cmd;
    sbta_pkg::stat_t stat;
    logic [14:0]     result_offset;
    logic [14:0]     top_now;

    sbta_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sbta_dp #(
        .BUF_BYTES (BUF_BYTES)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (s_tuser),
        .req_size      (s_tdata[14:0]),
        .block_offset  (s_tdata[29:15]),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .result_offset (result_offset),
        .status        (m_tuser),
        .top_now       (top_now)
    );

    assign m_tdata = {2'b00, top_now, result_offset};

endmodule

// ===== src/sbta_checker.sv =====
// ----------------------------------------------------------------------------
// Stack boundary-tag allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_boundary_tag_allocator_assert.svh"

module sbta_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser,
    input logic        cfg_we,
    input logic [10:0] cfg_wdata
);

    `SBTA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `SBTA_ASSERT_IMP(a_fail_no_offset, m_tvalid && m_tuser, m_tdata[14:0] == 15'd0)
    `SBTA_ASSERT_IMP(a_offset_above_top, m_tvalid && (m_tdata[14:0] != 15'd0),
                     m_tdata[14:0] == 15'(m_tdata[29:15] + 15'd4))
    `SBTA_ASSERT_NXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)

endmodule

bind stack_boundary_tag_allocator sbta_checker u_sbta_checker (.*);

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Stack boundary-tag allocator testbench
// Drives allocate and release requests with bursty traffic and a stalling
// receiver, predicts every result with an in-bench boundary-tag store, and
// compares result offset, status and stack top on each result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int  BUF      = 16384;
    localparam int  NWORDS   = BUF / 4 + 1;
    localparam bit  OP_ALLOC = 1'b0;
    localparam bit  OP_FREE  = 1'b1;
    localparam bit  ST_OK    = 1'b0;
    localparam bit  ST_OOM   = 1'b1;

    typedef struct packed {
        logic        op;
        logic [14:0] size;
        logic [14:0] offset;
    } req_t;

    typedef struct packed {
        logic [14:0] offset;
        logic        status;
        logic [14:0] top;
    } rsp_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we;
    logic [10:0] cfg_wdata;

    stack_boundary_tag_allocator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    req_t        pend_q[$];
    rsp_t        rsp_q[$];
    logic [14:0] live_q[$];
    logic [31:0] tags[0:NWORDS-1];
    logic [31:0] heap_top;
    logic [10:0] reserve;
    int          n_err, n_rsp, n_ok, n_oom, n_free;
    bit          sender_pause, want_hold;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("stack_boundary_tag_allocator verification failed");
        $finish;
    end

    function automatic logic [31:0] tag_rd(longint idx);
        if (idx < 0 || idx >= NWORDS) return 32'd0;
        return tags[idx];
    endfunction

    function automatic void tag_wr(longint idx, logic [31:0] v);
        if (idx >= 0 && idx < NWORDS) tags[idx] = v;
    endfunction

    function automatic void pop_block(longint hdr);
        longint t;
        logic [31:0] nx;
        t = longint'(heap_top) + (longint'(tag_rd(hdr) & sbta_pkg::TAG_SIZE) << 2);
        if (t > BUF) t = BUF;
        heap_top = 32'(t);
        if (heap_top == BUF) return;
        nx = tag_rd(heap_top >> 2);
        if (nx & sbta_pkg::TAG_FREE) begin
            t = longint'(heap_top) + (longint'(nx & sbta_pkg::TAG_SIZE) << 2);
            if (t > BUF) t = BUF;
            heap_top = 32'(t);
        end
    endfunction

    function automatic void free_inner(longint i);
        longint lo, sz;
        logic [31:0] nx, merged;
        if (tag_rd(i) & sbta_pkg::TAG_PREVFREE) begin
            lo = i - (longint'(tag_rd(i - 1)) + 1);
            if (lo >= 0 && lo < NWORDS) begin
                tag_wr(lo, ((tag_rd(lo) + tag_rd(i)) & sbta_pkg::TAG_SIZE)
                           | sbta_pkg::TAG_FREE);
                i = lo;
            end
        end
        sz = tag_rd(i) & sbta_pkg::TAG_SIZE;
        nx = tag_rd(i + sz);
        if (nx & sbta_pkg::TAG_FREE) begin
            merged = ((tag_rd(i) + nx) & sbta_pkg::TAG_SIZE) | sbta_pkg::TAG_FREE;
            tag_wr(i, merged);
            sz = merged & sbta_pkg::TAG_SIZE;
            tag_wr(i + sz - 1, 32'(sz - 1));
            return;
        end
        tag_wr(i + sz - 1, 32'(sz - 1));
        tag_wr(i + sz, tag_rd(i + sz) | sbta_pkg::TAG_PREVFREE);
        tag_wr(i, tag_rd(i) | sbta_pkg::TAG_FREE);
    endfunction

    function automatic rsp_t allocator_step(req_t r);
        rsp_t   e;
        longint words, old, hdr, bot;
        e = '0;
        if (r.op == OP_ALLOC) begin
            words = (r.size == 0) ? 1 : ((longint'(r.size) - 1) >> 2) + 2;
            if (longint'(heap_top) - words * 4 < longint'(reserve)) begin
                e.status = ST_OOM;
                n_oom++;
            end else begin
                old = heap_top >> 2;
                tag_wr(old, tag_rd(old) & sbta_pkg::TAG_SIZE);
                heap_top = 32'(longint'(heap_top) - words * 4);
                tag_wr(heap_top >> 2, 32'(words));
                e.offset = 15'(heap_top + 32'd4);
                n_ok++;
            end
        end else if (r.offset >= 4) begin
            hdr = (r.offset - 4) >> 2;
            bot = heap_top >> 2;
            if (hdr >= bot && hdr < BUF / 4) begin
                n_free++;
                if (hdr == bot) pop_block(hdr);
                else free_inner(hdr);
            end
        end
        e.top = heap_top[14:0];
        return e;
    endfunction

    function automatic void queue_req(logic op, logic [14:0] sz, logic [14:0] off);
        req_t r;
        rsp_t e;
        r = '{op: op, size: sz, offset: off};
        e = allocator_step(r);
        if (op == OP_ALLOC && e.status == ST_OK) live_q.push_back(e.offset);
        pend_q.push_back(r);
        rsp_q.push_back(e);
    endfunction

    function automatic void queue_release(int k);
        logic [14:0] off;
        off = live_q[k];
        live_q.delete(k);
        queue_req(OP_FREE, 15'($urandom), off);
    endfunction

    task automatic report_mismatch(string what, int got, int exp);
        $display("mismatch on result %0d: %s got %0d expected %0d", n_rsp, what, got, exp);
        n_err++;
    endtask

    task automatic drain_and_set(logic [10:0] v);
        wait (pend_q.size() == 0 && rsp_q.size() == 0);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        reserve = v;
    endtask

    task automatic random_phase(int n);
        int p;
        for (int k = 0; k < n; k++) begin
            p = $urandom_range(0, 99);
            if (p < 55) begin
                if ($urandom_range(0, 19) == 0)
                    queue_req(OP_ALLOC, 15'($urandom), 15'($urandom));
                else
                    queue_req(OP_ALLOC, 15'($urandom_range(0, 300)), 15'($urandom));
            end else if (p < 93 && live_q.size() > 0) begin
                queue_release($urandom_range(0, live_q.size() - 1));
            end else begin
                case ($urandom_range(0, 3))
                    0: queue_req(OP_FREE, 15'($urandom), 15'd0);
                    1: queue_req(OP_FREE, 15'($urandom), 15'($urandom_range(1, 3)));
                    2: queue_req(OP_FREE, 15'($urandom),
                                 15'($urandom_range(16388, 32767)));
                    default: queue_req(OP_FREE, 15'($urandom),
                                       15'($urandom_range(0, heap_top + 3)));
                endcase
            end
            if ((k % 16) == 15) wait (pend_q.size() < 8);
        end
    endtask

    // stimulus
    initial begin
        for (int i = 0; i < NWORDS; i++) tags[i] = '0;
        heap_top = BUF;
        reserve  = sbta_pkg::RESERVE_RST;
        n_err = 0; n_rsp = 0; n_ok = 0; n_oom = 0; n_free = 0;
        sender_pause = 1'b0;
        want_hold    = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        drain_and_set(11'd0);
        queue_req(OP_ALLOC, 15'd0, 15'd0);
        queue_req(OP_ALLOC, 15'd1, 15'd0);
        queue_req(OP_ALLOC, 15'd4, 15'd0);
        queue_req(OP_ALLOC, 15'd5, 15'd0);
        queue_req(OP_ALLOC, 15'd40, 15'd0);
        queue_req(OP_ALLOC, 15'd16384, 15'd0);
        queue_req(OP_ALLOC, 15'h7FFF, 15'h7FFF);
        queue_req(OP_FREE, 15'h7FFF, 15'd0);
        queue_req(OP_FREE, 15'd0, 15'd2);
        queue_req(OP_FREE, 15'd0, 15'h7FFF);
        queue_req(OP_FREE, 15'd0, 15'd4);
        queue_release(1);
        queue_release(2);
        queue_release(1);
        queue_release(1);
        queue_release(0);
        queue_req(OP_ALLOC, 15'd16380, 15'd0);
        queue_req(OP_ALLOC, 15'd8, 15'd0);
        queue_req(OP_FREE, 15'd0, 15'd4);

        drain_and_set(11'd1024);
        want_hold = 1'b1;
        random_phase(60);
        sender_pause = 1'b1;
        wait (rsp_q.size() == pend_q.size());
        sender_pause = 1'b0;
        random_phase(60);

        drain_and_set(11'd64);
        random_phase(130);
        drain_and_set(11'd2047);
        random_phase(40);
        drain_and_set(11'd0);
        random_phase(130);
        drain_and_set(11'($urandom_range(0, 1024)));
        random_phase(100);

        wait (pend_q.size() == 0 && rsp_q.size() == 0);
        repeat (30) @(posedge aclk);
        $display("checked %0d results: %0d allocations, %0d out-of-memory, %0d releases",
                 n_rsp, n_ok, n_oom, n_free);
        $display("reserve swept across 0, 64, 1024 and full range under stalls");
        if (n_err == 0) begin
            $display("stack_boundary_tag_allocator verification clean");
        end else begin
            $display("stack_boundary_tag_allocator verification failed");
        end
        $finish;
    end

    // request driver: bursts with random gaps
    bit s_fire;
    int burst_left, gap_left;
    initial begin
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        s_fire = 1'b0; burst_left = 0; gap_left = 0;
    end

    always @(posedge aclk) begin
        s_fire <= s_tvalid && s_tready;
    end

    always @(negedge aclk) begin
        req_t r;
        if (!s_tvalid || s_fire) begin
            if (s_fire) pend_q.pop_front();
            if (gap_left > 0 || sender_pause) begin
                if (gap_left > 0) gap_left--;
                s_tvalid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                r = pend_q[0];
                s_tvalid <= 1'b1;
                s_tuser  <= r.op;
                s_tdata  <= {2'b00, r.offset, r.size};
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                end else if (--burst_left == 0) begin
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver with its own stall pattern and one long hold-off
    int hold_left, stall_mode;
    initial begin
        m_tready = 1'b0; hold_left = 0; stall_mode = 0;
    end

    always @(negedge aclk) begin
        if (want_hold && pend_q.size() > 20) begin
            want_hold = 1'b0;
            hold_left = 400;
        end
        if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // result monitor
    always @(posedge aclk) begin
        rsp_t e;
        if (aresetn && m_tvalid && m_tready) begin
            n_rsp++;
            if (rsp_q.size() == 0) begin
                report_mismatch("unexpected result, top", m_tdata[29:15], -1);
            end else begin
                e = rsp_q.pop_front();
                if (m_tdata[14:0] !== e.offset)
                    report_mismatch("result_offset", m_tdata[14:0], e.offset);
                if (m_tuser !== e.status)
                    report_mismatch("status", m_tuser, e.status);
                if (m_tdata[29:15] !== e.top)
                    report_mismatch("top_now", m_tdata[29:15], e.top);
            end
        end
    end

endmodule

// ===== sim.f =====
+incdir+src
src/sbta_pkg.sv
src/sbta_ctrl.sv
src/sbta_dp.sv
src/stack_boundary_tag_allocator.sv
src/sbta_checker.sv
dv/tb_top.sv
